// File: rtl/core/dqsa_pkg.sv
// ----------------------------------------------------------------------------
// dqsa_pkg: shared types for the dual queue shared array unit
// Request and result beats, request and status codes, and sequencer states.
// ----------------------------------------------------------------------------
package dqsa_pkg;

  localparam int unsigned DATA_W = 32;

  // request codes (six and seven are unused and ignored)
  typedef enum logic [2:0] {
    REQ_PUSH_A = 3'd0,
    REQ_PUSH_B = 3'd1,
    REQ_POP_A  = 3'd2,
    REQ_POP_B  = 3'd3,
    REQ_LIST_A = 3'd4,
    REQ_LIST_B = 3'd5
  } req_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // sequencer states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_WALK = 1'b1
  } state_e;

  // input beat
  typedef struct packed {
    logic        [2:0]        req_type;
    logic signed [DATA_W-1:0] push_value;
  } req_t;

  // result beat
  typedef struct packed {
    logic        [1:0]        status;
    logic signed [DATA_W-1:0] data_value;
    logic                     last;
  } result_t;

  // controller status toward the output stage
  typedef struct packed {
    logic res_valid;  // registered push/empty result pending
    logic rd_pend;    // store read data arrives this cycle
    logic rd_last;    // that read is the final beat of its request
  } ctrl_stat_t;

endpackage

// File: rtl/core/dqsa_store.sv
// ----------------------------------------------------------------------------
// dqsa_store: shared element array
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module dqsa_store #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic                                clk_i,
  input  logic                                we_i,
  input  logic [AW-1:0]                       waddr_i,
  input  logic signed [dqsa_pkg::DATA_W-1:0]  wdata_i,
  input  logic                                re_i,
  input  logic [AW-1:0]                       raddr_i,
  output logic signed [dqsa_pkg::DATA_W-1:0]  rdata_o
);
  import dqsa_pkg::*;

  logic signed [DATA_W-1:0] mem_q [DEPTH];
  logic signed [DATA_W-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/dqsa_ctrl.sv
// ----------------------------------------------------------------------------
// dqsa_ctrl: pointer registers and request sequencer
// Queue A pointers are kept biased by one (zero means empty), queue B
// pointers as is (DEPTH means empty). A list request walks the store with
// one shared address stepper, one read per cycle.
// ----------------------------------------------------------------------------
module dqsa_ctrl #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  dqsa_pkg::req_t                      req_i,
  output logic                                busy_o,
  output logic                                we_o,
  output logic [AW-1:0]                       waddr_o,
  output logic signed [dqsa_pkg::DATA_W-1:0]  wdata_o,
  output logic                                re_o,
  output logic [AW-1:0]                       raddr_o,
  output dqsa_pkg::ctrl_stat_t                stat_o,
  output dqsa_pkg::result_t                   res_o
);
  import dqsa_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);
  localparam logic [AW-1:0] STEP_C  = AW'(1);

  state_e state_q, state_d;
  logic [CW-1:0] ha_q, ha_d, ta_q, ta_d, hb_q, hb_d, tb_q, tb_d;
  logic [AW-1:0] walk_q, walk_d, end_q, end_d;
  logic          up_q, up_d;
  logic          res_valid_q, res_valid_d;
  result_t       res_q, res_d;
  logic          rd_pend_q, rd_pend_d, rd_last_q, rd_last_d;

  logic          accept, a_empty, b_empty, full;
  logic [AW-1:0] first_addr, last_addr, cur_addr, step_addr;
  logic          first_up;

  assign accept  = start_i && (state_q == S_IDLE);
  assign a_empty = (ha_q == '0);
  assign b_empty = (hb_q == DEPTH_C);
  assign full    = (ta_q == tb_q);

  // list bounds of the requested queue
  always_comb begin
    if (req_i.req_type == REQ_LIST_B) begin
      first_addr = hb_q[AW-1:0];
      last_addr  = tb_q[AW-1:0];
      first_up   = 1'b0;
    end else begin
      first_addr = AW'(ha_q - ONE_C);
      last_addr  = AW'(ta_q - ONE_C);
      first_up   = 1'b1;
    end
  end

  // shared address stepper
  assign cur_addr  = (state_q == S_WALK) ? walk_q : first_addr;
  assign step_addr = (state_q == S_WALK ? up_q : first_up) ?
                     cur_addr + STEP_C : cur_addr - STEP_C;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && cur_addr != last_addr &&
            ((req_i.req_type == REQ_LIST_A && !a_empty) ||
             (req_i.req_type == REQ_LIST_B && !b_empty))) begin
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        if (walk_q == end_q) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and store control
  always_comb begin
    ha_d        = ha_q;
    ta_d        = ta_q;
    hb_d        = hb_q;
    tb_d        = tb_q;
    walk_d      = step_addr;
    end_d       = end_q;
    up_d        = up_q;
    res_valid_d = 1'b0;
    res_d       = '{status: ST_OK, data_value: '0, last: 1'b1};
    rd_pend_d   = 1'b0;
    rd_last_d   = 1'b1;
    we_o        = 1'b0;
    waddr_o     = ta_q[AW-1:0];
    wdata_o     = req_i.push_value;
    re_o        = 1'b0;
    raddr_o     = cur_addr;

    if (state_q == S_WALK) begin
      re_o      = 1'b1;
      rd_pend_d = 1'b1;
      rd_last_d = (walk_q == end_q);
    end else if (accept) begin
      end_d = last_addr;
      up_d  = first_up;
      unique case (req_i.req_type)
        REQ_PUSH_A: begin
          res_valid_d = 1'b1;
          if (full) begin
            res_d.status = ST_FULL;
          end else begin
            we_o    = 1'b1;
            waddr_o = ta_q[AW-1:0];
            ta_d    = ta_q + ONE_C;
            if (a_empty) begin
              ha_d = ONE_C;
            end
          end
        end
        REQ_PUSH_B: begin
          res_valid_d = 1'b1;
          if (full) begin
            res_d.status = ST_FULL;
          end else begin
            we_o    = 1'b1;
            waddr_o = AW'(tb_q - ONE_C);
            tb_d    = tb_q - ONE_C;
            if (b_empty) begin
              hb_d = DEPTH_C - ONE_C;
            end
          end
        end
        REQ_POP_A: begin
          if (a_empty) begin
            res_valid_d  = 1'b1;
            res_d.status = ST_EMPTY;
          end else begin
            re_o      = 1'b1;
            raddr_o   = AW'(ha_q - ONE_C);
            rd_pend_d = 1'b1;
            if (ha_q == ta_q) begin
              ha_d = '0;
              ta_d = '0;
            end else begin
              ha_d = ha_q + ONE_C;
            end
          end
        end
        REQ_POP_B: begin
          if (b_empty) begin
            res_valid_d  = 1'b1;
            res_d.status = ST_EMPTY;
          end else begin
            re_o      = 1'b1;
            raddr_o   = hb_q[AW-1:0];
            rd_pend_d = 1'b1;
            if (hb_q == tb_q) begin
              hb_d = DEPTH_C;
              tb_d = DEPTH_C;
            end else begin
              hb_d = hb_q - ONE_C;
            end
          end
        end
        REQ_LIST_A, REQ_LIST_B: begin
          if ((req_i.req_type == REQ_LIST_A) ? a_empty : b_empty) begin
            res_valid_d  = 1'b1;
            res_d.status = ST_EMPTY;
          end else begin
            re_o      = 1'b1;
            rd_pend_d = 1'b1;
            rd_last_d = (first_addr == last_addr);
          end
        end
        default: ;  // unused codes: no beat, no state change
      endcase
    end
  end

  // registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ha_q        <= '0;
      ta_q        <= '0;
      hb_q        <= DEPTH_C;
      tb_q        <= DEPTH_C;
      res_valid_q <= 1'b0;
      rd_pend_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      ha_q        <= ha_d;
      ta_q        <= ta_d;
      hb_q        <= hb_d;
      tb_q        <= tb_d;
      res_valid_q <= res_valid_d;
      rd_pend_q   <= rd_pend_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    walk_q    <= walk_d;
    end_q     <= end_d;
    up_q      <= up_d;
    res_q     <= res_d;
    rd_last_q <= rd_last_d;
  end

  assign busy_o = (state_q == S_WALK);
  assign stat_o = '{res_valid: res_valid_q, rd_pend: rd_pend_q, rd_last: rd_last_q};
  assign res_o  = res_q;

endmodule

// File: rtl/core/dual_queue_shared_array_unit.sv
// ----------------------------------------------------------------------------
// dual_queue_shared_array_unit: two FIFO queues in one shared array
// Queue A grows up from the bottom, queue B down from the top.
// Every accepted request but the unused codes gives its first beat in the
// cycle after start. Push and pop never raise busy; a list holds busy
// until its last store read is issued, one read per cycle via the stepper.
// Reset clears both queues to empty; array contents are kept undefined.
// Result beats cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module dual_queue_shared_array_unit #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  dqsa_pkg::req_t       req_i,
  output logic                 strobe,
  output dqsa_pkg::result_t    result_o
);
  import dqsa_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);

  logic                     we, re;
  logic [AW-1:0]            waddr, raddr;
  logic signed [DATA_W-1:0] wdata, rdata;
  ctrl_stat_t               stat;
  result_t                  res;

  dqsa_ctrl #(.DEPTH(DEPTH), .AW(AW)) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .req_i   (req_i),
    .busy_o  (busy),
    .we_o    (we),
    .waddr_o (waddr),
    .wdata_o (wdata),
    .re_o    (re),
    .raddr_o (raddr),
    .stat_o  (stat),
    .res_o   (res)
  );

  dqsa_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // output beat: store data for reads, registered result otherwise
  always_comb begin
    if (stat.rd_pend) begin
      result_o = '{status: ST_OK, data_value: rdata, last: stat.rd_last};
    end else begin
      result_o = res;
    end
  end

  assign strobe = stat.rd_pend || stat.res_valid;

  // read beats and registered beats never collide
  a_no_collide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(stat.rd_pend && stat.res_valid))
    else $error("read beat and registered beat in the same cycle");

  // a list in progress delivers a beat every cycle
  a_walk_beats: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> strobe)
    else $error("list walk missed a beat");

  // a beat that is not last is followed at once by another
  a_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe && !result_o.last |=> strobe)
    else $error("list beats not contiguous");

  // busy only rises after an accepted request
  a_busy_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a request");

endmodule
